// File: src/uf_pkg.sv
// Shared types, operation codes and controller/datapath command encodings for the union-find engine.
package uf_pkg;

  localparam int ElemW = 11;

  // Operation codes of an input item
  localparam logic [1:0] OP_FIND  = 2'd0;
  localparam logic [1:0] OP_MERGE = 2'd1;
  localparam logic [1:0] OP_INIT  = 2'd2;

  // Cursor select codes
  localparam logic [2:0] CUR_HOLD   = 3'd0;
  localparam logic [2:0] CUR_A      = 3'd1;
  localparam logic [2:0] CUR_B      = 3'd2;
  localparam logic [2:0] CUR_FOLLOW = 3'd3;
  localparam logic [2:0] CUR_START  = 3'd4;

  // Size read address select codes
  localparam logic [1:0] SZ_ROOT = 2'd0;
  localparam logic [1:0] SZ_RA   = 2'd1;
  localparam logic [1:0] SZ_RB   = 2'd2;

  // Result select codes
  localparam logic [1:0] RES_ZERO  = 2'd0;
  localparam logic [1:0] RES_BAD   = 2'd1;
  localparam logic [1:0] RES_FIND  = 2'd2;
  localparam logic [1:0] RES_MERGE = 2'd3;

  typedef struct packed {
    logic [1:0]       op;
    logic [ElemW-1:0] elem_a;
    logic [ElemW-1:0] elem_b;
  } uf_in_t;

  typedef struct packed {
    logic [ElemW-1:0] root;
    logic [ElemW-1:0] set_size;
    logic             joined;
    logic             bad_index;
  } uf_out_t;

  typedef struct packed {
    logic       item_load;
    logic [2:0] cur_sel;
    logic       root_load;
    logic       par_wr;
    logic       ra_load;
    logic       rb_load;
    logic [1:0] sz_sel;
    logic       sa_load;
    logic       link;
    logic [1:0] res_sel;
    logic       res_load;
    logic       out_load;
    logic       clr_start;
    logic       clr_step;
  } uf_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       bad;
    logic       climb_done;
    logic       comp_done;
    logic       clr_last;
  } uf_stat_t;

endpackage

// File: src/union_find_engine.sv
// Top level of the disjoint-set engine with path compression and union by size.
// Usage:
//   Input channel in_valid/in_ready/in_data carries one item: op (find, merge, init),
//   elem_a and elem_b. Result channel out_valid/out_ready/out_data returns exactly
//   one item per input: root, set_size, joined, bad_index.
//   cfg_we/cfg_wdata writes element_count (reset 1024); write only while idle.
// Operation (one item at a time, bounded by the single parent memory port):
//   find: a climb from elem_a to its root, then a second walk that points the path at the root;
//   merge: two such walks, for elem_a and then elem_b, then a link by union by size.
//   A bad index or unused op returns without a walk.
//   init: a sweep over all entries, one table entry rewritten per cycle.
// Reset: a sweep over all MAX_ELEMENTS entries rebuilds all singletons; in_ready stays low
//   until it ends. Configuration writes are taken during the sweep.
// Stall: a finished result sits in the output register until out_ready; the next
//   item is still accepted and worked on, and its result waits for the register.
module union_find_engine #(
  parameter int MAX_ELEMENTS = 1024
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  uf_pkg::uf_in_t           in_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output uf_pkg::uf_out_t          out_data,
  input  logic                     cfg_we,
  input  logic [uf_pkg::ElemW-1:0] cfg_wdata
);
  import uf_pkg::*;

  uf_cmd_t  cmd;
  uf_stat_t stat;

  uf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  uf_datapath #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_data  (out_data)
  );

endmodule

// File: src/uf_datapath.sv
// Datapath: parent and size memories, find cursor, root and size registers, result registers.
module uf_datapath #(
  parameter int MAX_ELEMENTS = 1024
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  uf_pkg::uf_in_t              in_data,
  input  logic                        cfg_we,
  input  logic [uf_pkg::ElemW-1:0]    cfg_wdata,
  input  uf_pkg::uf_cmd_t             cmd,
  output uf_pkg::uf_stat_t            stat,
  output uf_pkg::uf_out_t             out_data
);
  import uf_pkg::*;

  localparam int AW = $clog2(MAX_ELEMENTS + 1);
  localparam logic [16:0] MaxW = 17'(MAX_ELEMENTS);

  typedef logic [AW-1:0] idx_t;

  idx_t par_mem  [0:MAX_ELEMENTS];
  idx_t size_mem [0:MAX_ELEMENTS];

  uf_in_t           item_r;
  logic [ElemW-1:0] count_r;
  idx_t             cur_r, cur_nxt, start_r, root_r, ra_r, rb_r, sa_r;
  idx_t             par_q, size_q, clr_r, sz_addr;
  idx_t             a_idx, b_idx, winner, loser, sum;
  uf_out_t          res_r, res_nxt, out_r;
  logic [16:0]      lim, a_ext, b_ext;
  logic             ok_a, ok_b;

  // Range check against the saturated element count
  assign lim   = ({6'd0, count_r} > MaxW) ? MaxW : {6'd0, count_r};
  assign a_ext = {6'd0, item_r.elem_a};
  assign b_ext = {6'd0, item_r.elem_b};
  assign ok_a  = (item_r.elem_a != '0) && (a_ext <= lim);
  assign ok_b  = (item_r.elem_b != '0) && (b_ext <= lim);
  assign a_idx = AW'(item_r.elem_a);
  assign b_idx = AW'(item_r.elem_b);

  // Pick the merge winner: larger set, first root on a tie
  assign winner = (sa_r < size_q) ? rb_r : ra_r;
  assign loser  = (sa_r < size_q) ? ra_r : rb_r;
  assign sum    = sa_r + size_q;

  // Next cursor; the parent memory is always read at it
  always_comb begin
    unique case (cmd.cur_sel)
      CUR_A:      cur_nxt = a_idx;
      CUR_B:      cur_nxt = b_idx;
      CUR_FOLLOW: cur_nxt = par_q;
      CUR_START:  cur_nxt = start_r;
      default:    cur_nxt = cur_r;
    endcase
  end

  always_comb begin
    unique case (cmd.sz_sel)
      SZ_RA:   sz_addr = ra_r;
      SZ_RB:   sz_addr = rb_r;
      default: sz_addr = root_r;
    endcase
  end

  // Build the pending result
  always_comb begin
    res_nxt = '0;
    unique case (cmd.res_sel)
      RES_BAD:  res_nxt.bad_index = 1'b1;
      RES_FIND: begin
        res_nxt.root     = ElemW'(ra_r);
        res_nxt.set_size = ElemW'(size_q);
      end
      RES_MERGE: begin
        if (ra_r == rb_r) begin
          res_nxt.root     = ElemW'(ra_r);
          res_nxt.set_size = ElemW'(sa_r);
        end else begin
          res_nxt.root     = ElemW'(winner);
          res_nxt.set_size = ElemW'(sum);
          res_nxt.joined   = 1'b1;
        end
      end
      default: res_nxt = '0;
    endcase
  end

  // Parent memory: sweep, path rewrite or merge link; registered read
  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      par_mem[clr_r] <= clr_r;
    end else if (cmd.par_wr) begin
      par_mem[cur_r] <= root_r;
    end else if (cmd.link && (ra_r != rb_r)) begin
      par_mem[loser] <= winner;
    end
    par_q <= par_mem[cur_nxt];
  end

  // Size memory: sweep or merge growth; registered read
  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      size_mem[clr_r] <= idx_t'(1);
    end else if (cmd.link && (ra_r != rb_r)) begin
      size_mem[winner] <= sum;
    end
    size_q <= size_mem[sz_addr];
  end

  // Sweep counter and configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r   <= idx_t'(1);
      count_r <= 11'd1024;
    end else begin
      if (cmd.clr_start) begin
        clr_r <= idx_t'(1);
      end else if (cmd.clr_step) begin
        clr_r <= clr_r + idx_t'(1);
      end
      if (cfg_we) begin
        count_r <= cfg_wdata;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.item_load) item_r <= in_data;
    cur_r <= cur_nxt;
    if (cmd.cur_sel == CUR_A) start_r <= a_idx;
    if (cmd.cur_sel == CUR_B) start_r <= b_idx;
    if (cmd.root_load) root_r <= cur_r;
    if (cmd.ra_load)   ra_r   <= root_r;
    if (cmd.rb_load)   rb_r   <= root_r;
    if (cmd.sa_load)   sa_r   <= size_q;
    if (cmd.res_load)  res_r  <= res_nxt;
    if (cmd.out_load)  out_r  <= res_r;
  end

  assign stat.op         = item_r.op;
  assign stat.bad        = (item_r.op == OP_MERGE) ? !(ok_a && ok_b) : !ok_a;
  assign stat.climb_done = (par_q == cur_r);
  assign stat.comp_done  = (cur_r == root_r);
  assign stat.clr_last   = (clr_r == idx_t'(MAX_ELEMENTS));
  assign out_data        = out_r;

endmodule

// File: src/uf_ctrl.sv
// Controller: sequences clearing sweeps, the two-pass finds, merge linking and result hand-off.
module uf_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  uf_pkg::uf_stat_t stat,
  output uf_pkg::uf_cmd_t  cmd
);
  import uf_pkg::*;

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_DECODE = 4'd2;
  localparam logic [3:0] S_CLIMB  = 4'd3;
  localparam logic [3:0] S_COMP   = 4'd4;
  localparam logic [3:0] S_FDONE  = 4'd5;
  localparam logic [3:0] S_SZA    = 4'd6;
  localparam logic [3:0] S_SZB    = 4'd7;
  localparam logic [3:0] S_EMIT   = 4'd8;

  logic [3:0] state_r, state_nxt;
  logic       phase_r, phase_nxt;
  logic       init_pend_r, init_pend_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       is_access;

  assign is_access = (stat.op == OP_FIND) || (stat.op == OP_MERGE);

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    init_pend_nxt = init_pend_r;
    cmd           = '0;
    in_ready      = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) begin
          init_pend_nxt = 1'b0;
          state_nxt     = init_pend_r ? S_EMIT : S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.item_load = 1'b1;
          state_nxt     = S_DECODE;
        end
      end
      S_DECODE: begin
        phase_nxt = 1'b0;
        if (stat.op == OP_INIT) begin
          cmd.clr_start = 1'b1;
          cmd.res_sel   = RES_ZERO;
          cmd.res_load  = 1'b1;
          init_pend_nxt = 1'b1;
          state_nxt     = S_CLEAR;
        end else if (is_access && !stat.bad) begin
          cmd.cur_sel = CUR_A;
          state_nxt   = S_CLIMB;
        end else begin
          cmd.res_sel  = is_access ? RES_BAD : RES_ZERO;
          cmd.res_load = 1'b1;
          state_nxt    = S_EMIT;
        end
      end
      S_CLIMB: begin
        if (stat.climb_done) begin
          cmd.root_load = 1'b1;
          cmd.cur_sel   = CUR_START;
          state_nxt     = S_COMP;
        end else begin
          cmd.cur_sel = CUR_FOLLOW;
        end
      end
      S_COMP: begin
        if (stat.comp_done) begin
          state_nxt = S_FDONE;
        end else begin
          cmd.par_wr  = 1'b1;
          cmd.cur_sel = CUR_FOLLOW;
        end
      end
      S_FDONE: begin
        if (!phase_r) begin
          cmd.ra_load = 1'b1;
          if (stat.op == OP_FIND) begin
            cmd.sz_sel = SZ_ROOT;
            state_nxt  = S_SZA;
          end else begin
            phase_nxt   = 1'b1;
            cmd.cur_sel = CUR_B;
            state_nxt   = S_CLIMB;
          end
        end else begin
          cmd.rb_load = 1'b1;
          cmd.sz_sel  = SZ_RA;
          state_nxt   = S_SZA;
        end
      end
      S_SZA: begin
        cmd.sa_load = 1'b1;
        if (stat.op == OP_FIND) begin
          cmd.res_sel  = RES_FIND;
          cmd.res_load = 1'b1;
          state_nxt    = S_EMIT;
        end else begin
          cmd.sz_sel = SZ_RB;
          state_nxt  = S_SZB;
        end
      end
      S_SZB: begin
        cmd.res_sel  = RES_MERGE;
        cmd.res_load = 1'b1;
        cmd.link     = 1'b1;
        state_nxt    = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold the result until taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      phase_r     <= 1'b0;
      init_pend_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      init_pend_r <= init_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_DECODE))
    else $error("accepted item not decoded");

  a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && (!out_valid_r || out_ready)) |=> (out_valid_r && state_r == S_IDLE))
    else $error("result not presented");

  a_walk_op: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLIMB || state_r == S_COMP) |-> (is_access && !stat.bad))
    else $error("walk on invalid item");

  a_phase_merge: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r && state_r != S_IDLE && state_r != S_DECODE && state_r != S_EMIT
      && state_r != S_CLEAR) |-> (stat.op == OP_MERGE))
    else $error("second find outside merge");
`endif

endmodule
